// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define DPWR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DPWR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPWR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPWR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/dpwr_pkg.sv =====
// Package for the densest-point-within-radius block: default sizes,
// port widths and the sequencer state type. No dependencies.
package dpwr_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_BITS_DEF = 16;

  localparam int IN_COORD_W = 16;
  localparam int OUT_FIELD_W = 8;
  localparam int RADIUS_W = 16;
  localparam int R2_W = 2 * RADIUS_W;
  localparam int OUT_CNT_MAX = 255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_EMIT
  } state_t;

endpackage

// ===== design/densest_point_within_radius_top.sv =====
// Densest point within radius: point store, all-pairs neighbor count, argmax.
// Depends on dpwr_pkg.sv and assert_macros.svh.

// Points are loaded one item per cycle while busy is low: each item accepted
// with start high is written into an on-chip point memory at the next free
// slot. A point that arrives with the memory full (MAX_POINTS entries) is
// dropped and the overflow flag of the set is raised. The item with
// in_last_point set (stored if there is room) starts the search: for every
// stored point i the block re-reads all n stored points through the single
// read port of the memory, runs them through a three-stage
// difference/square/compare pipeline and counts those at squared distance
// strictly below radius squared. The point with the highest count wins; ties
// go to the lower index, and with no neighbors at all the result is index 0,
// count 0. Busy stays high through the search: for each point i the block
// does a fetch and a latch, reads the stored points one per cycle, then
// drains the pipeline and compares. The result appears on out_* for exactly
// one cycle with out_valid high; there is no way to hold it off, so the
// receiver must take it in that cycle. Afterwards the store is empty again.
// The radius is written through cfg_wr_en/cfg_wr_data and may only change
// while busy is low and no search is pending.
module densest_point_within_radius_top #(
  parameter int MAX_POINTS = dpwr_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = dpwr_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_wr_en,
  input  logic [dpwr_pkg::RADIUS_W-1:0]          cfg_wr_data,
  // input items
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [dpwr_pkg::IN_COORD_W-1:0] in_x_coord,
  input  logic signed [dpwr_pkg::IN_COORD_W-1:0] in_y_coord,
  input  logic                                   in_last_point,
  // result items
  output logic                                   out_valid,
  output logic [dpwr_pkg::OUT_FIELD_W-1:0]       out_densest_index,
  output logic [dpwr_pkg::OUT_FIELD_W-1:0]       out_neighbour_count,
  output logic                                   out_overflow
);

`include "assert_macros.svh"

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int LD_W   = $clog2(MAX_POINTS + 1);
  localparam int CNT_W  = IDX_W;
  localparam int ABS_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int CMP_W  = (DIST_W > dpwr_pkg::R2_W) ? DIST_W : dpwr_pkg::R2_W;
  localparam int PT_W   = 2 * COORD_BITS;

  // Point memory: {x, y} per entry, one write and one registered read port.
  logic [PT_W-1:0] pt_mem [MAX_POINTS];
  logic [PT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic            mem_we;
  logic [PT_W-1:0] wr_data;

  dpwr_pkg::state_t state_r, state_nxt;

  logic [dpwr_pkg::RADIUS_W-1:0] radius_r;
  logic [dpwr_pkg::R2_W-1:0]     r2_r;
  logic [LD_W-1:0]  ld_cnt_r;
  logic             dropped_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] best_cnt_r;
  logic [IDX_W-1:0] best_idx_r;
  logic signed [COORD_BITS-1:0] pi_x_r, pi_y_r;

  // Scan pipeline: read data, abs differences, squares.
  logic             s1_v_r, s2_v_r, s3_v_r;
  logic             s1_self_r, s2_self_r, s3_self_r;
  logic [ABS_W-1:0] adx_r, ady_r;
  logic [SQ_W-1:0]  sqx_r, sqy_r;

  logic             accept;
  logic             store_full;
  logic             j_last, i_last;
  logic             pipe_busy;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic signed [ABS_W-1:0] dx, dy;
  logic [ABS_W-1:0] adx, ady;
  logic [DIST_W-1:0] dsq;
  logic             near;

  assign busy       = (state_r != dpwr_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign store_full = (ld_cnt_r == LD_W'(MAX_POINTS));
  assign j_last     = ((LD_W'(j_r) + LD_W'(1)) == ld_cnt_r);
  assign i_last     = ((LD_W'(i_r) + LD_W'(1)) == ld_cnt_r);
  assign pipe_busy  = s1_v_r || s2_v_r || s3_v_r;
  assign wr_data    = {COORD_BITS'(in_x_coord), COORD_BITS'(in_y_coord)};

  // Sequencer: next state, memory control.
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    rd_addr   = j_r;
    unique case (state_r)
      dpwr_pkg::ST_IDLE: begin
        if (accept) begin
          mem_we = !store_full;
          if (in_last_point) begin
            state_nxt = dpwr_pkg::ST_FETCH;
          end
        end
      end
      dpwr_pkg::ST_FETCH: begin
        rd_addr   = i_r;
        state_nxt = dpwr_pkg::ST_LATCH;
      end
      dpwr_pkg::ST_LATCH: begin
        state_nxt = dpwr_pkg::ST_SCAN;
      end
      dpwr_pkg::ST_SCAN: begin
        if (j_last) begin
          state_nxt = dpwr_pkg::ST_DRAIN;
        end
      end
      dpwr_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = dpwr_pkg::ST_EVAL;
        end
      end
      dpwr_pkg::ST_EVAL: begin
        state_nxt = i_last ? dpwr_pkg::ST_EMIT : dpwr_pkg::ST_FETCH;
      end
      dpwr_pkg::ST_EMIT: begin
        state_nxt = dpwr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = dpwr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpwr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Point memory: write on load, registered read every cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[ld_cnt_r[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= pt_mem[rd_addr];
  end

  // Pipeline datapath: difference and abs, then square, then compare.
  assign rd_x = rd_data_r[PT_W-1:COORD_BITS];
  assign rd_y = rd_data_r[COORD_BITS-1:0];
  assign dx   = ABS_W'(pi_x_r) - ABS_W'(rd_x);
  assign dy   = ABS_W'(pi_y_r) - ABS_W'(rd_y);
  assign adx  = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
  assign ady  = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
  assign dsq  = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign near = (CMP_W'(dsq) < CMP_W'(r2_r));

  always_ff @(posedge clk) begin
    adx_r <= adx;
    ady_r <= ady;
    sqx_r <= SQ_W'(adx_r * adx_r);
    sqy_r <= SQ_W'(ady_r * ady_r);
    s2_self_r <= s1_self_r;
    s3_self_r <= s2_self_r;
    s1_self_r <= (j_r == i_r);
    r2_r <= dpwr_pkg::R2_W'(radius_r * radius_r);
    if (state_r == dpwr_pkg::ST_LATCH) begin
      pi_x_r <= rd_x;
      pi_y_r <= rd_y;
    end
  end

  // Control registers: load count, sweep counters, best so far, result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= '0;
      ld_cnt_r    <= '0;
      dropped_r   <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      best_cnt_r  <= '0;
      best_idx_r  <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= (state_r == dpwr_pkg::ST_EMIT);
      s1_v_r    <= (state_r == dpwr_pkg::ST_SCAN);
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      // clear per point i; count a neighbor leaving the pipeline, skipping
      // the point itself
      if (state_r == dpwr_pkg::ST_LATCH) begin
        cnt_r <= '0;
      end else if (s3_v_r && !s3_self_r && near) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      unique case (state_r)
        dpwr_pkg::ST_IDLE: begin
          if (accept) begin
            if (store_full) begin
              dropped_r <= 1'b1;
            end else begin
              ld_cnt_r <= ld_cnt_r + LD_W'(1);
            end
            i_r        <= '0;
            best_cnt_r <= '0;
            best_idx_r <= '0;
          end
        end
        dpwr_pkg::ST_LATCH: begin
          j_r <= '0;
        end
        dpwr_pkg::ST_SCAN: begin
          j_r <= j_r + IDX_W'(1);
        end
        dpwr_pkg::ST_EVAL: begin
          // strict compare keeps the earliest index on a tie
          if (cnt_r > best_cnt_r) begin
            best_cnt_r <= cnt_r;
            best_idx_r <= i_r;
          end
          i_r <= i_r + IDX_W'(1);
        end
        dpwr_pkg::ST_EMIT: begin
          ld_cnt_r  <= '0;
          dropped_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields, loaded during the emit state alongside out_valid.
  always_ff @(posedge clk) begin
    if (state_r == dpwr_pkg::ST_EMIT) begin
      out_densest_index <= dpwr_pkg::OUT_FIELD_W'(best_idx_r);
      out_neighbour_count <= (32'(best_cnt_r) > 32'(dpwr_pkg::OUT_CNT_MAX)) ?
                             dpwr_pkg::OUT_FIELD_W'(dpwr_pkg::OUT_CNT_MAX) :
                             dpwr_pkg::OUT_FIELD_W'(best_cnt_r);
      out_overflow <= dropped_r;
    end
  end

  `DPWR_ASSERT(a_out_after_emit, clk, rst_n, out_valid |-> $past(state_r == dpwr_pkg::ST_EMIT), "result strobe without emit")
  `DPWR_ASSERT(a_no_write_full, clk, rst_n, mem_we |-> !store_full, "write into a full point store")
  `DPWR_ASSERT(a_pipe_in_search, clk, rst_n, pipe_busy |-> busy, "scan pipeline active while idle")
  `DPWR_ASSERT(a_empty_after_out, clk, rst_n, out_valid |-> (ld_cnt_r == '0 && !dropped_r), "store not emptied after result")
  `DPWR_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result strobe right after reset")

endmodule
